### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the heap queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is held.
`define BMHQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that is also evaluated while reset is held.
`define BMHQ_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// Heap queue package
// Transaction types and command and status codes of the max-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

    localparam int COUNT_W = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;
    localparam logic [1:0] CMD_BUILD  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [31:0]  removed_value;
        logic signed [31:0]  top_value;
        logic [COUNT_W-1:0]  count;
    } t_out;

endpackage

`default_nettype wire

### sv/bmhq_cmp.sv
// ----------------------------------------------------------------------------
// Heap queue compare unit
// Signed strict compare of a candidate against the current winner.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_cmp (
    input  wire logic signed [31:0] i_cand,
    input  wire logic               i_cand_ok,
    input  wire logic signed [31:0] i_incumb,
    output logic                    o_take,
    output logic signed [31:0]      o_winner
);

    // Equal values never replace the incumbent.
    assign o_take   = i_cand_ok && (i_cand > i_incumb);
    assign o_winner = o_take ? i_cand : i_incumb;

endmodule

`default_nettype wire

### sv/bmhq_mem.sv
// ----------------------------------------------------------------------------
// Heap queue store
// Element memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_mem #(
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic signed [31:0]       i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic signed [31:0]            o_rdata0,
    output logic signed [31:0]            o_rdata1
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd0;
    logic signed [31:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd0 <= r_mem[i_raddr0];
            r_rd1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

`default_nettype wire

### sv/bmhq_seq.sv
// ----------------------------------------------------------------------------
// Heap queue sequencer
// Walks the heap one level at a time using the store and the compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_seq #(
    parameter int CAPACITY = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire bmhq_pkg::t_in   i_cmd,
    output logic                 o_idle,
    output logic                 o_res_valid,
    input  wire logic            i_res_take,
    output bmhq_pkg::t_out       o_res
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int XW    = AW + 2;
    localparam int OutCW = bmhq_pkg::COUNT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEL_RD = 4'd1;
    localparam logic [3:0] S_DEL_LD = 4'd2;
    localparam logic [3:0] S_SD_RD  = 4'd3;
    localparam logic [3:0] S_SD_CL  = 4'd4;
    localparam logic [3:0] S_SD_CR  = 4'd5;
    localparam logic [3:0] S_SU_RD  = 4'd6;
    localparam logic [3:0] S_SU_CMP = 4'd7;
    localparam logic [3:0] S_BLD_RD = 4'd8;
    localparam logic [3:0] S_BLD_LD = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0]         r_state,     n_state;
    logic [1:0]         r_cmd,       n_cmd;
    logic [CW-1:0]      r_count,     n_count;
    logic [CW-1:0]      r_k,         n_k;
    logic [AW-1:0]      r_node,      n_node;
    logic signed [31:0] r_v,         n_v;
    logic signed [31:0] r_best_val,  n_best_val;
    logic [AW-1:0]      r_best_idx,  n_best_idx;
    logic               r_best_move, n_best_move;
    logic signed [31:0] r_top,       n_top;
    logic signed [31:0] r_removed,   n_removed;
    logic [1:0]         r_status,    n_status;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic signed [31:0] w_wdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr0;
    logic [AW-1:0]      w_raddr1;
    logic signed [31:0] w_rdata0;
    logic signed [31:0] w_rdata1;

    logic signed [31:0] w_cand;
    logic               w_cand_ok;
    logic signed [31:0] w_incumb;
    logic               w_take;
    logic signed [31:0] w_winner;

    logic [XW-1:0]      w_lc;
    logic [XW-1:0]      w_rc;
    logic [XW-1:0]      w_size;
    logic               w_lc_ok;
    logic               w_rc_ok;
    logic [AW-1:0]      w_parent;
    logic               w_full;
    logic [3:0]         w_sift_end;

    bmhq_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_re     (w_re),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rdata0),
        .o_rdata1 (w_rdata1)
    );

    bmhq_cmp u_cmp (
        .i_cand    (w_cand),
        .i_cand_ok (w_cand_ok),
        .i_incumb  (w_incumb),
        .o_take    (w_take),
        .o_winner  (w_winner)
    );

    assign w_lc       = XW'({r_node, 1'b1});
    assign w_rc       = w_lc + XW'(1);
    assign w_size     = XW'(r_count);
    assign w_lc_ok    = w_lc < w_size;
    assign w_rc_ok    = w_rc < w_size;
    assign w_parent   = AW'((r_node - AW'(1)) >> 1);
    assign w_full     = r_count >= CW'(CAPACITY);
    assign w_sift_end = (r_cmd == bmhq_pkg::CMD_BUILD && r_k != '0) ? S_BLD_RD : S_FIN;

    // The compare unit is steered by the state.
    always_comb begin
        w_cand    = w_rdata0;
        w_cand_ok = 1'b0;
        w_incumb  = r_v;
        case (r_state)
            S_SD_CL: begin
                w_cand    = w_rdata0;
                w_cand_ok = 1'b1;
                w_incumb  = r_v;
            end
            S_SD_CR: begin
                w_cand    = w_rdata1;
                w_cand_ok = w_rc_ok;
                w_incumb  = r_best_val;
            end
            S_SU_CMP: begin
                w_cand    = r_v;
                w_cand_ok = 1'b1;
                w_incumb  = w_rdata0;
            end
            default: begin
                w_cand_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_k         = r_k;
        n_node      = r_node;
        n_v         = r_v;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_best_move = r_best_move;
        n_removed   = r_removed;
        n_status    = r_status;
        w_we        = 1'b0;
        w_waddr     = r_node;
        w_wdata     = r_v;
        w_re        = 1'b0;
        w_raddr0    = AW'(w_lc);
        w_raddr1    = AW'(w_rc);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd     = i_cmd.command;
                    n_v       = i_cmd.value;
                    n_status  = bmhq_pkg::ST_OK;
                    n_removed = '0;
                    n_state   = S_FIN;
                    case (i_cmd.command)
                        bmhq_pkg::CMD_INSERT: begin
                            if (w_full) begin
                                n_status = bmhq_pkg::ST_FULL;
                            end else begin
                                n_node  = AW'(r_count);
                                n_count = r_count + CW'(1);
                                n_state = S_SU_RD;
                            end
                        end
                        bmhq_pkg::CMD_LOAD: begin
                            if (w_full) begin
                                n_status = bmhq_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = AW'(r_count);
                                w_wdata = i_cmd.value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        bmhq_pkg::CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_status = bmhq_pkg::ST_EMPTY;
                            end else begin
                                n_removed = r_top;
                                n_count   = r_count - CW'(1);
                                n_state   = S_DEL_RD;
                            end
                        end
                        default: begin
                            n_k = r_count >> 1;
                            if ((r_count >> 1) != '0) begin
                                n_state = S_BLD_RD;
                            end
                        end
                    endcase
                end
            end
            S_DEL_RD: begin
                // The count already points at the last element.
                w_re     = 1'b1;
                w_raddr0 = AW'(r_count);
                n_state  = S_DEL_LD;
            end
            S_DEL_LD: begin
                n_v    = w_rdata0;
                n_node = '0;
                n_state = (r_count == '0) ? S_FIN : S_SD_RD;
            end
            S_SD_RD: begin
                if (!w_lc_ok) begin
                    w_we    = 1'b1;
                    n_state = w_sift_end;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_SD_CL;
                end
            end
            S_SD_CL: begin
                n_best_val  = w_winner;
                n_best_idx  = w_take ? AW'(w_lc) : r_node;
                n_best_move = w_take;
                n_state     = S_SD_CR;
            end
            S_SD_CR: begin
                if (!(w_take || r_best_move)) begin
                    w_we    = 1'b1;
                    n_state = w_sift_end;
                end else begin
                    // The larger child moves up into the hole.
                    w_we    = 1'b1;
                    w_wdata = w_winner;
                    n_node  = w_take ? AW'(w_rc) : r_best_idx;
                    n_state = S_SD_RD;
                end
            end
            S_SU_RD: begin
                if (r_node == '0) begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_re     = 1'b1;
                    w_raddr0 = w_parent;
                    n_state  = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                w_we = 1'b1;
                if (w_take) begin
                    w_wdata = w_rdata0;
                    n_node  = w_parent;
                    n_state = S_SU_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_BLD_RD: begin
                w_re     = 1'b1;
                w_raddr0 = AW'(r_k - CW'(1));
                n_node   = AW'(r_k - CW'(1));
                n_k      = r_k - CW'(1);
                n_state  = S_BLD_LD;
            end
            S_BLD_LD: begin
                n_v     = w_rdata0;
                n_state = S_SD_RD;
            end
            S_FIN: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The root is mirrored in a register so that it is always at hand.
    assign n_top = (w_we && w_waddr == '0) ? w_wdata : r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_k         <= n_k;
        r_node      <= n_node;
        r_v         <= n_v;
        r_best_val  <= n_best_val;
        r_best_idx  <= n_best_idx;
        r_best_move <= n_best_move;
        r_top       <= n_top;
        r_removed   <= n_removed;
        r_status    <= n_status;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);

    always_comb begin
        o_res.status        = r_status;
        o_res.removed_value = r_removed;
        o_res.top_value     = (r_count != '0) ? r_top : 32'sd0;
        o_res.count         = OutCW'(r_count);
    end

endmodule

`default_nettype wire

### sv/binary_max_heap_queue_top.sv
// ----------------------------------------------------------------------------
// Binary max-heap priority queue
// Keeps up to CAPACITY signed 32-bit values as a max-heap and runs one
// command per transaction: insert, delete maximum, unordered load, build.
//
// Every input transaction returns exactly one result transaction with the
// status, the removed root, the new root and the element count. The block
// works on one command at a time and stalls its input until the command has
// finished; a result waiting at the output does not keep the next command
// from starting, but that command's result waits until the output is free.
// Each heap level costs one store read followed by compares in a single
// shared comparator, so timing follows the tree height (six at 64 entries).
// Load, the full and empty refusals and a build over fewer than two elements
// go straight to the result. Insert climbs one level per parent read and
// compare and stops at the root or below a parent that is not smaller.
// Delete maximum of the last element skips the sift; otherwise the last
// element is moved to the root and sifted down. Build sifts down each
// internal node, last one first. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module binary_max_heap_queue_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire bmhq_pkg::t_in   i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output bmhq_pkg::t_out       o_out
);

    localparam int CntOutW = bmhq_pkg::COUNT_W;

    logic           w_idle;
    logic           w_res_valid;
    logic           w_res_take;
    bmhq_pkg::t_out w_res;

    logic           r_out_valid;
    bmhq_pkg::t_out r_out;

    // A new command is taken only while the sequencer is idle.
    assign o_in_stall = !w_idle;

    // The result register frees up when empty or when its transaction leaves.
    assign w_res_take = !r_out_valid || !i_out_stall;

    bmhq_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && w_idle),
        .i_cmd       (i_in),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Every accepted command leaves the sequencer busy, so the input stalls after it.
    `BMHQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall) |=> o_in_stall,
        "input accepted while a command was still running")

    // A refused insert or load only happens with a full store.
    `BMHQ_ASSERT(a_full_count, i_clk, i_rst_n,
        (o_out_valid && o_out.status == bmhq_pkg::ST_FULL) |->
            (o_out.count == CntOutW'(CAPACITY)),
        "full status with a store that is not full")

    // An empty delete leaves an empty heap and reports zeros.
    `BMHQ_ASSERT(a_empty_result, i_clk, i_rst_n,
        (o_out_valid && o_out.status == bmhq_pkg::ST_EMPTY) |->
            (o_out.count == '0 && o_out.removed_value == 32'sd0 &&
             o_out.top_value == 32'sd0),
        "empty status with nonzero result fields")

    // Reset drops any pending result.
    `BMHQ_ASSERT_RST(a_reset_clears_out, i_clk,
        !i_rst_n |=> !o_out_valid,
        "result still valid after reset")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Heap queue testbench
// Drives the max-heap queue with a directed table and then with phased random
// command mixes, predicts every result with a behavioral heap, and checks
// each result transaction field by field while both sides idle and stall.
// ----------------------------------------------------------------------------

module testbench;

    // The block is built with its default capacity of 64 entries.
    localparam int CAPACITY        = 64;
    localparam int RANDOM_ITEMS    = 300;
    // Last stretch of the random part runs with no idling on either side.
    localparam int QUIET_ITEMS     = 40;
    // The receiver holds off once for this many cycles so the block backs up.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT     = 150;
    // A build over a full store sifts 32 nodes, plus a receiver stall burst;
    // the limit on quiet cycles leaves a wide margin over both.
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_TAIL      = 64;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    // Command mix of one random phase.
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    // One row of the directed table. A row either repeats one command or,
    // when rnd is set, draws a fresh value for every repetition. Rows with
    // typed set carry their expected result; the rest use the predictor.
    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] val;
        int                 reps;
        bit                 rnd;
        bit                 typed;
        bmhq_pkg::t_out     res;
    } t_stim_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    bmhq_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_stall;
    bmhq_pkg::t_out o_out;

    // Behavioral copy of the heap: the store and the element count.
    logic signed [31:0] heap_mem [0:CAPACITY-1];
    int                 heap_len;

    bmhq_pkg::t_out pending_results[$];
    int   results_checked;
    int   mismatches;
    int   cmd_seen [0:3];
    int   full_refusals;
    int   empty_refusals;
    int   peak_len;

    bit   quiet_tail;
    bit   hold_off_req;
    bit   sender_calm;
    int   idle_cycles;

    binary_max_heap_queue_top #(
        .CAPACITY    (CAPACITY)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Heap predictor. Comparisons are strict and signed, so equal values stay
    // where they are, and on a tie between two children the left one wins.
    // ------------------------------------------------------------------------

    function automatic void heap_swap(int a, int b);
        logic signed [31:0] t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    function automatic void heap_sink(int node, int size);
        int best;
        int lc;
        int rc;
        while (1) begin
            best = node;
            lc   = 2 * node + 1;
            rc   = 2 * node + 2;
            if (lc < size && heap_mem[lc] > heap_mem[best]) best = lc;
            if (rc < size && heap_mem[rc] > heap_mem[best]) best = rc;
            if (best == node) return;
            heap_swap(node, best);
            node = best;
        end
    endfunction

    function automatic void heap_rise(int node);
        int up;
        while (node > 0) begin
            up = (node - 1) / 2;
            if (!(heap_mem[node] > heap_mem[up])) return;
            heap_swap(node, up);
            node = up;
        end
    endfunction

    // Applies one command to the behavioral heap and returns its result.
    function automatic bmhq_pkg::t_out heap_apply(bmhq_pkg::t_in item);
        bmhq_pkg::t_out r;
        int             k;
        r        = '0;
        r.status = bmhq_pkg::ST_OK;
        case (item.command)
            bmhq_pkg::CMD_INSERT, bmhq_pkg::CMD_LOAD: begin
                if (heap_len >= CAPACITY) begin
                    r.status = bmhq_pkg::ST_FULL;
                    full_refusals++;
                end else begin
                    heap_mem[heap_len] = item.value;
                    heap_len++;
                    if (item.command == bmhq_pkg::CMD_INSERT) heap_rise(heap_len - 1);
                end
            end
            bmhq_pkg::CMD_DELETE: begin
                if (heap_len == 0) begin
                    r.status = bmhq_pkg::ST_EMPTY;
                    empty_refusals++;
                end else begin
                    r.removed_value = heap_mem[0];
                    heap_mem[0]     = heap_mem[heap_len - 1];
                    heap_len--;
                    heap_sink(0, heap_len);
                end
            end
            default: begin
                // Build: heapify every internal node, last one first.
                k = heap_len / 2;
                while (k > 0) begin
                    k--;
                    heap_sink(k, heap_len);
                end
            end
        endcase
        cmd_seen[item.command]++;
        if (heap_len > peak_len) peak_len = heap_len;
        r.top_value = (heap_len > 0) ? heap_mem[0] : '0;
        r.count     = heap_len[bmhq_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Values lean toward the extremes and a narrow band around zero, so that
    // ties between parents and children come up often.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3, 4: return $signed($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_cmd(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 50)      return bmhq_pkg::CMD_INSERT;
                else if (r < 80) return bmhq_pkg::CMD_LOAD;
                else if (r < 90) return bmhq_pkg::CMD_DELETE;
                else             return bmhq_pkg::CMD_BUILD;
            end
            MIX_DRAIN: begin
                if (r < 70)      return bmhq_pkg::CMD_DELETE;
                else if (r < 85) return bmhq_pkg::CMD_INSERT;
                else if (r < 92) return bmhq_pkg::CMD_LOAD;
                else             return bmhq_pkg::CMD_BUILD;
            end
            default: begin
                if (r < 25)      return bmhq_pkg::CMD_INSERT;
                else if (r < 50) return bmhq_pkg::CMD_DELETE;
                else if (r < 75) return bmhq_pkg::CMD_LOAD;
                else             return bmhq_pkg::CMD_BUILD;
            end
        endcase
    endfunction

    function automatic t_stim_row row(logic [1:0] cmd, logic signed [31:0] val,
                                      int reps = 1, bit rnd = 1'b0);
        t_stim_row s;
        s.cmd   = cmd;
        s.val   = val;
        s.reps  = reps;
        s.rnd   = rnd;
        s.typed = 1'b0;
        s.res   = '0;
        return s;
    endfunction

    function automatic t_stim_row row_typed(logic [1:0] cmd, logic signed [31:0] val,
                                            logic [1:0] st, logic signed [31:0] gone,
                                            logic signed [31:0] top, int cnt);
        t_stim_row s;
        s                   = row(cmd, val);
        s.typed             = 1'b1;
        s.res.status        = st;
        s.res.removed_value = gone;
        s.res.top_value     = top;
        s.res.count         = cnt[bmhq_pkg::COUNT_W-1:0];
        return s;
    endfunction

    // Offers one transaction and holds it until the block takes it. The
    // prediction is made at the accepting edge so the heap copy stays in
    // step with the block; a typed row replaces the predicted result.
    task automatic offer(bmhq_pkg::t_in item, bit typed = 1'b0,
                         bmhq_pkg::t_out typed_res = '0);
        bmhq_pkg::t_out predicted;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        predicted = heap_apply(item);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Lowers valid for a number of cycles.
    task automatic sender_gap(int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (!quiet_tail && !sender_calm && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 18));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, drain, verdict.
    // ------------------------------------------------------------------------
    initial begin
        t_stim_row     dir_tab[$];
        bmhq_pkg::t_in item;
        t_mix          mix;
        int            phase_left;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        heap_len   = 0;
        foreach (cmd_seen[c]) cmd_seen[c] = 0;

        // Reset is held low from the start and released at a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty heap: refusal on delete, a build that moves nothing.
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_DELETE, 0, bmhq_pkg::ST_EMPTY, 0, 0, 0));
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_BUILD, 0, bmhq_pkg::ST_OK, 0, 0, 0));
        // Single element: a build leaves it alone, a delete empties the heap.
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_LOAD, 5, bmhq_pkg::ST_OK, 0, 5, 1));
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_BUILD, 0, bmhq_pkg::ST_OK, 0, 5, 1));
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_DELETE, 0, bmhq_pkg::ST_OK, 5, 0, 0));
        // Extremes of the value range, and an equal value that must not climb.
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_INSERT, VAL_MAX, bmhq_pkg::ST_OK, 0,
                                    VAL_MAX, 1));
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_INSERT, VAL_MIN, bmhq_pkg::ST_OK, 0,
                                    VAL_MAX, 2));
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_INSERT, -1, bmhq_pkg::ST_OK, 0,
                                    VAL_MAX, 3));
        dir_tab.push_back(row(bmhq_pkg::CMD_INSERT, 0));
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_INSERT, VAL_MAX, bmhq_pkg::ST_OK, 0,
                                    VAL_MAX, 5));
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_DELETE, 0, bmhq_pkg::ST_OK, VAL_MAX,
                                    VAL_MAX, 4));
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_DELETE, 0, bmhq_pkg::ST_OK, VAL_MAX,
                                    0, 3));
        dir_tab.push_back(row(bmhq_pkg::CMD_DELETE, 0, 3));
        dir_tab.push_back(row_typed(bmhq_pkg::CMD_DELETE, 0, bmhq_pkg::ST_EMPTY, 0, 0, 0));
        // Two equal children under a smaller root: the left child moves up.
        dir_tab.push_back(row(bmhq_pkg::CMD_LOAD, 7));
        dir_tab.push_back(row(bmhq_pkg::CMD_LOAD, 9));
        dir_tab.push_back(row(bmhq_pkg::CMD_LOAD, 9));
        dir_tab.push_back(row(bmhq_pkg::CMD_BUILD, 0));
        dir_tab.push_back(row(bmhq_pkg::CMD_DELETE, 0));
        // Unordered loads put in order by one build, then partly drained.
        dir_tab.push_back(row(bmhq_pkg::CMD_LOAD, 0, 10, 1'b1));
        dir_tab.push_back(row(bmhq_pkg::CMD_BUILD, 0));
        dir_tab.push_back(row(bmhq_pkg::CMD_DELETE, 0, 3));
        // Fill the store past its capacity: the last loads are refused, then
        // an insert is refused too, and a build runs over the full store.
        dir_tab.push_back(row(bmhq_pkg::CMD_LOAD, 0, CAPACITY, 1'b1));
        dir_tab.push_back(row(bmhq_pkg::CMD_INSERT, 0, 1, 1'b1));
        dir_tab.push_back(row(bmhq_pkg::CMD_BUILD, 0));

        foreach (dir_tab[i]) begin
            repeat (dir_tab[i].reps) begin
                maybe_gap();
                item.command = dir_tab[i].cmd;
                item.value   = dir_tab[i].rnd ? pick_value() : dir_tab[i].val;
                offer(item, dir_tab[i].typed, dir_tab[i].res);
            end
        end

        // Random part: phases of 8 to 40 commands, each with its own mix
        // and its own idling habit. The mix leans toward filling when the
        // heap is low and toward draining when it is high, so both the full
        // and the empty refusals come up repeatedly.
        phase_left = 0;
        mix        = MIX_DRAIN;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left  = $urandom_range(8, 40);
                sender_calm = ($urandom_range(0, 2) == 0);
                if (heap_len < 12)      mix = ($urandom_range(0, 3) != 0) ? MIX_FILL : MIX_EVEN;
                else if (heap_len > 52) mix = ($urandom_range(0, 3) != 0) ? MIX_DRAIN : MIX_EVEN;
                else                    mix = t_mix'($urandom_range(0, 2));
            end
            phase_left--;
            if (n == HOLD_OFF_AT) hold_off_req = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            maybe_gap();
            item.command = pick_cmd(mix);
            item.value   = pick_value();
            offer(item);
        end
        sender_gap(1);

        // Wait for every outstanding result, then watch a while longer for
        // any stray result transaction.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("Covered %0d inserts, %0d deletes, %0d loads and %0d builds; peak depth %0d.",
                 cmd_seen[bmhq_pkg::CMD_INSERT], cmd_seen[bmhq_pkg::CMD_DELETE],
                 cmd_seen[bmhq_pkg::CMD_LOAD], cmd_seen[bmhq_pkg::CMD_BUILD], peak_len);
        $display("Saw %0d full and %0d empty refusals; %0d results checked, %0d bad.",
                 full_refusals, empty_refusals, results_checked, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall bursts of random length, open stretches in between,
    // one long hold-off on request, and no stalls at all in the quiet tail.
    // ------------------------------------------------------------------------
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                // Keep the output blocked long enough for the block to back up
                // into its input while the sender keeps offering.
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted result transaction is compared with the
    // oldest expectation, field by field.
    // ------------------------------------------------------------------------
    function automatic void field_cmp(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        bmhq_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, expected nothing, actual %p",
                         $realtime, o_out);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                field_cmp("status", 32'(want.status), 32'(o_out.status));
                field_cmp("removed_value", want.removed_value, o_out.removed_value);
                field_cmp("top_value", want.top_value, o_out.top_value);
                field_cmp("count", 32'(want.count), 32'(o_out.count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which neither side completes a transaction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $realtime, idle_cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

### sim.f
+incdir+sv
sv/bmhq_pkg.sv
sv/bmhq_cmp.sv
sv/bmhq_mem.sv
sv/bmhq_seq.sv
sv/binary_max_heap_queue_top.sv
tb/sv/testbench.sv
